>>> hdl/bpd_pkg.sv
package bpd_pkg;

  // Fixed-point format of every internal length, time and speed.
  localparam int FRAC      = 16;
  localparam int K_DRAG    = ((20 << FRAC) + 500) / 1000;
  localparam int G_ACC     = ((98 << FRAC) + 5) / 10;
  localparam int TOL       = ((1 << FRAC) + 500) / 1000;
  localparam int U_MAX     = 2 << FRAC;
  localparam int EXP_TERMS = 24;
  localparam int AIM_MAX   = 2097151;
  localparam int AIM_MIN   = -2097152;

  localparam int WORD    = 64;
  localparam int D_W     = 22;
  localparam int Y_W     = 22;
  localparam int LS_W    = 15;
  localparam int VEL_W   = LS_W + 8;
  localparam int U_W     = 17;
  localparam int KV_W    = 18;
  localparam int TERM_W  = 17;
  localparam int SUM_W   = 20;
  localparam int R_W     = 23;
  localparam int Q_W     = 39;
  localparam int T_W     = FRAC + 5;
  localparam int VT_W    = 28;
  localparam int RM_W    = 28;
  localparam int GT_W    = 25;
  localparam int DROP_W  = 29;
  localparam int DIVR_W  = 23;
  localparam int N_W     = 5;
  localparam int ITERS_W = 5;

  typedef enum logic [3:0] {
    OP_EXP_MUL,
    OP_EXP_DIV,
    OP_SQ_D,
    OP_SQ_H,
    OP_SQRT,
    OP_Q,
    OP_EQ,
    OP_T,
    OP_VT,
    OP_VTM,
    OP_RM,
    OP_GT,
    OP_DROP
  } op_t;

  typedef enum logic [2:0] {
    FIN_INVALID,
    FIN_TOVF,
    FIN_AOVF,
    FIN_CONV,
    FIN_LIMIT
  } fin_t;

  typedef enum logic [1:0] {
    ST_CONV  = 2'd0,
    ST_LIMIT = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

  typedef struct packed {
    logic           load;
    logic           start;
    op_t            op;
    logic [N_W-1:0] n;
    logic           upd;
    logic           fin;
    fin_t           kind;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic invalid;
    logic t_big;
    logic a_ovf;
    logic conv;
  } stat_t;

endpackage

>>> hdl/bpd_mul.sv
module bpd_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bpd_pkg::WORD-1:0]   a,
  input  logic [bpd_pkg::WORD-1:0]   b,
  output logic [bpd_pkg::WORD-1:0]   p,
  output logic                       done
);

  logic [bpd_pkg::WORD-1:0] a_r, b_r, acc_r, part;
  logic                     busy_r, done_r;

  // One byte of the multiplier per cycle; stops as soon as no bits remain.
  assign part = a_r * bpd_pkg::WORD'(b_r[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && b_r != '0) begin
      acc_r <= acc_r + part;
      a_r   <= a_r << 8;
      b_r   <= b_r >> 8;
    end
  end

  assign p    = acc_r;
  assign done = done_r;

endmodule

>>> hdl/bpd_div.sv
module bpd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bpd_pkg::WORD-1:0]     dividend,
  input  logic [bpd_pkg::DIVR_W-1:0]   divisor,
  output logic [bpd_pkg::WORD-1:0]     quo,
  output logic                         done
);

  localparam int CNT_W = $clog2(bpd_pkg::WORD + 1);

  logic [bpd_pkg::WORD-1:0]   q_r;
  logic [bpd_pkg::DIVR_W-1:0] rem_r, dvs_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r, done_r;
  logic [bpd_pkg::DIVR_W:0]   sh, diff;
  logic                       fits;

  // Restoring division, one quotient bit per cycle; the quotient shifts
  // in where the dividend shifts out.
  assign sh   = {rem_r, q_r[bpd_pkg::WORD-1]};
  assign fits = sh >= {1'b0, dvs_r};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(bpd_pkg::WORD);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[bpd_pkg::WORD-2:0], fits};
      rem_r <= fits ? diff[bpd_pkg::DIVR_W-1:0] : sh[bpd_pkg::DIVR_W-1:0];
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

>>> hdl/bpd_sqrt.sv
module bpd_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bpd_pkg::WORD-1:0] x,
  output logic [bpd_pkg::WORD-1:0] res,
  output logic                     done
);

  logic [bpd_pkg::WORD-1:0] x_r, res_r, bit_r, trial;
  logic                     busy_r, done_r, fits;

  // Digit-by-digit integer square root, two radicand bits per cycle.
  assign trial = res_r + bit_r;
  assign fits  = x_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      res_r <= '0;
      bit_r <= bpd_pkg::WORD'(1) << (bpd_pkg::WORD - 2);
    end else if (busy_r) begin
      if (fits) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

>>> hdl/bpd_dp.sv
module bpd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bpd_pkg::LS_W-1:0]          cfg_data,
  input  logic [bpd_pkg::D_W-1:0]           in_distance,
  input  logic signed [bpd_pkg::Y_W-1:0]    in_target_height,
  input  bpd_pkg::cmd_t                     cmd,
  output bpd_pkg::stat_t                    stat,
  output logic signed [bpd_pkg::Y_W-1:0]    aim
);

  localparam int W = bpd_pkg::WORD;

  logic [bpd_pkg::LS_W-1:0]       ls_r;
  logic [bpd_pkg::D_W-1:0]        d_r;
  logic signed [bpd_pkg::Y_W-1:0] y_r, h_r, aim_r, aim_nxt;
  logic [bpd_pkg::U_W-1:0]        u_r, u_nxt;
  logic [bpd_pkg::KV_W-1:0]       kv_r, kv_nxt;
  logic [bpd_pkg::TERM_W-1:0]     term_r;
  logic [bpd_pkg::SUM_W-1:0]      sum_r;
  logic [W-1:0]                   s_r;
  logic [bpd_pkg::R_W-1:0]        r_r;
  logic [bpd_pkg::Q_W-1:0]        q_r;
  logic [bpd_pkg::T_W-1:0]        t_r;
  logic [bpd_pkg::VT_W-1:0]       vt_r;
  logic [bpd_pkg::RM_W-1:0]       rm_r;
  logic [bpd_pkg::GT_W-1:0]       gt_r;
  logic [bpd_pkg::DROP_W-1:0]     drop_r;

  logic [bpd_pkg::VEL_W-1:0]      vel;
  logic [32:0]                    ku;
  logic [33:0]                    kvp;
  logic [bpd_pkg::Y_W-1:0]        mag;
  logic signed [33:0]             rise_e, drop_e, dy, h_new;

  logic                           mul_start, div_start, sq_start;
  logic [W-1:0]                   mul_a, mul_b, mul_p, div_n, div_q, sq_res;
  logic [bpd_pkg::DIVR_W-1:0]     div_d;
  logic                           mul_done, div_done, sq_done;

  assign vel    = {ls_r, 8'd0};
  assign ku     = 33'(bpd_pkg::K_DRAG) * 33'(in_distance);
  assign u_nxt  = ku[32:16];
  assign kvp    = 34'(bpd_pkg::K_DRAG) * 34'(vel);
  assign kv_nxt = kvp[33:16];

  assign mag = h_r[bpd_pkg::Y_W-1] ? ($unsigned(~h_r) + 22'd1) : $unsigned(h_r);

  // Height reached at the target, compared against the wanted height.
  assign rise_e = h_r[bpd_pkg::Y_W-1] ? -$signed({6'd0, rm_r}) : $signed({6'd0, rm_r});
  assign drop_e = $signed({5'd0, drop_r});
  assign dy     = 34'(y_r) - rise_e + drop_e;
  assign h_new  = 34'(h_r) + dy;

  assign stat.done    = mul_done | div_done | sq_done;
  assign stat.invalid = (d_r == '0) || (kv_r == '0) ||
                        ({1'b0, u_r} > 18'(bpd_pkg::U_MAX));
  assign stat.t_big   = |div_q[W-1:bpd_pkg::T_W];
  assign stat.a_ovf   = (h_new > 34'(bpd_pkg::AIM_MAX)) || (h_new < 34'(bpd_pkg::AIM_MIN));
  assign stat.conv    = (dy < 34'(bpd_pkg::TOL)) && (dy > -34'(bpd_pkg::TOL));

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = '0;
    unique case (cmd.op)
      bpd_pkg::OP_EXP_MUL: begin
        mul_start = cmd.start;
        mul_a     = W'(term_r);
        mul_b     = W'(u_r);
      end
      bpd_pkg::OP_EXP_DIV: begin
        div_start = cmd.start;
        div_n     = s_r >> bpd_pkg::FRAC;
        div_d     = bpd_pkg::DIVR_W'(cmd.n);
      end
      bpd_pkg::OP_SQ_D: begin
        mul_start = cmd.start;
        mul_a     = W'(d_r);
        mul_b     = W'(d_r);
      end
      bpd_pkg::OP_SQ_H: begin
        mul_start = cmd.start;
        mul_a     = W'(mag);
        mul_b     = W'(mag);
      end
      bpd_pkg::OP_SQRT: begin
        sq_start = cmd.start;
      end
      bpd_pkg::OP_Q: begin
        div_start = cmd.start;
        div_n     = W'(r_r) << bpd_pkg::FRAC;
        div_d     = bpd_pkg::DIVR_W'(d_r);
      end
      bpd_pkg::OP_EQ: begin
        mul_start = cmd.start;
        mul_a     = W'(sum_r);
        mul_b     = W'(q_r);
      end
      bpd_pkg::OP_T: begin
        div_start = cmd.start;
        div_n     = s_r;
        div_d     = bpd_pkg::DIVR_W'(kv_r);
      end
      bpd_pkg::OP_VT: begin
        mul_start = cmd.start;
        mul_a     = W'(vel);
        mul_b     = W'(t_r);
      end
      bpd_pkg::OP_VTM: begin
        mul_start = cmd.start;
        mul_a     = W'(vt_r);
        mul_b     = W'(mag);
      end
      bpd_pkg::OP_RM: begin
        div_start = cmd.start;
        div_n     = s_r;
        div_d     = r_r;
      end
      bpd_pkg::OP_GT: begin
        mul_start = cmd.start;
        mul_a     = W'(bpd_pkg::G_ACC);
        mul_b     = W'(t_r);
      end
      bpd_pkg::OP_DROP: begin
        mul_start = cmd.start;
        mul_a     = W'(gt_r);
        mul_b     = W'(t_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.kind)
      bpd_pkg::FIN_INVALID: aim_nxt = y_r;
      bpd_pkg::FIN_TOVF:    aim_nxt = h_r[bpd_pkg::Y_W-1] ? 22'(bpd_pkg::AIM_MIN)
                                                          : 22'(bpd_pkg::AIM_MAX);
      bpd_pkg::FIN_AOVF:    aim_nxt = h_new[33] ? 22'(bpd_pkg::AIM_MIN)
                                                : 22'(bpd_pkg::AIM_MAX);
      default:              aim_nxt = h_new[bpd_pkg::Y_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r <= 15'd5120;
    end else if (cfg_we) begin
      ls_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r    <= in_distance;
      y_r    <= in_target_height;
      h_r    <= in_target_height;
      u_r    <= u_nxt;
      kv_r   <= kv_nxt;
      term_r <= u_nxt;
      sum_r  <= bpd_pkg::SUM_W'(u_nxt);
    end
    if (cmd.upd) begin
      h_r <= h_new[bpd_pkg::Y_W-1:0];
    end
    if (cmd.fin) begin
      aim_r <= aim_nxt;
    end
    if (stat.done) begin
      case (cmd.op)
        bpd_pkg::OP_EXP_MUL: s_r <= mul_p;
        bpd_pkg::OP_EXP_DIV: begin
          term_r <= div_q[bpd_pkg::TERM_W-1:0];
          sum_r  <= sum_r + bpd_pkg::SUM_W'(div_q[bpd_pkg::TERM_W-1:0]);
        end
        bpd_pkg::OP_SQ_D:    s_r    <= mul_p;
        bpd_pkg::OP_SQ_H:    s_r    <= s_r + mul_p;
        bpd_pkg::OP_SQRT:    r_r    <= sq_res[bpd_pkg::R_W-1:0];
        bpd_pkg::OP_Q:       q_r    <= div_q[bpd_pkg::Q_W-1:0];
        bpd_pkg::OP_EQ:      s_r    <= mul_p;
        bpd_pkg::OP_T:       t_r    <= div_q[bpd_pkg::T_W-1:0];
        bpd_pkg::OP_VT:      vt_r   <= mul_p[43:16];
        bpd_pkg::OP_VTM:     s_r    <= mul_p;
        bpd_pkg::OP_RM:      rm_r   <= div_q[bpd_pkg::RM_W-1:0];
        bpd_pkg::OP_GT:      gt_r   <= mul_p[40:16];
        bpd_pkg::OP_DROP:    drop_r <= mul_p[45:17];
        default: ;
      endcase
    end
  end

  assign aim = aim_r;

  bpd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  bpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quo      (div_q),
    .done     (div_done)
  );

  bpd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (s_r),
    .res   (sq_res),
    .done  (sq_done)
  );

endmodule

>>> hdl/bpd_ctrl.sv
module bpd_ctrl #(
  parameter int MAX_ITERATIONS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpd_pkg::ITERS_W-1:0]   out_iters,
  output logic [1:0]                    out_status,
  input  bpd_pkg::stat_t                stat,
  output bpd_pkg::cmd_t                 cmd
);

  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
  localparam int CW     = (ITER_W > bpd_pkg::ITERS_W) ? ITER_W : bpd_pkg::ITERS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_UPDATE,
    S_FIN
  } state_t;

  state_t                        state_r, state_nxt;
  bpd_pkg::op_t                  op_r, op_nxt;
  logic [bpd_pkg::N_W-1:0]       n_r, n_nxt;
  logic [ITER_W-1:0]             i_r, i_nxt;
  bpd_pkg::fin_t                 kind_r, kind_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bpd_pkg::ITERS_W-1:0]   out_iters_r, out_iters_nxt;
  bpd_pkg::status_t              out_status_r, out_status_nxt;
  logic [CW-1:0]                 iter_ext;
  logic                          slot_free, last;

  assign slot_free = !out_valid_r || out_ready;
  assign last      = (i_r == ITER_W'(MAX_ITERATIONS - 1));
  assign iter_ext  = CW'(i_r) + CW'(1);

  assign cmd.load  = (state_r == S_IDLE) && in_valid;
  assign cmd.start = (state_r == S_ISSUE);
  assign cmd.op    = op_r;
  assign cmd.n     = n_r;
  assign cmd.upd   = (state_r == S_UPDATE) && !stat.a_ovf && !stat.conv && !last;
  assign cmd.fin   = (state_r == S_FIN) && slot_free;
  assign cmd.kind  = kind_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    kind_nxt       = kind_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_iters_nxt  = out_iters_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          i_nxt     = '0;
          n_nxt     = bpd_pkg::N_W'(2);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.invalid) begin
          kind_nxt  = bpd_pkg::FIN_INVALID;
          state_nxt = S_FIN;
        end else begin
          op_nxt    = bpd_pkg::OP_EXP_MUL;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (stat.done) begin
          state_nxt = S_ISSUE;
          unique case (op_r)
            bpd_pkg::OP_EXP_MUL: op_nxt = bpd_pkg::OP_EXP_DIV;
            bpd_pkg::OP_EXP_DIV: begin
              if (n_r == bpd_pkg::N_W'(bpd_pkg::EXP_TERMS)) begin
                op_nxt = bpd_pkg::OP_SQ_D;
              end else begin
                n_nxt  = n_r + bpd_pkg::N_W'(1);
                op_nxt = bpd_pkg::OP_EXP_MUL;
              end
            end
            bpd_pkg::OP_SQ_D: op_nxt = bpd_pkg::OP_SQ_H;
            bpd_pkg::OP_SQ_H: op_nxt = bpd_pkg::OP_SQRT;
            bpd_pkg::OP_SQRT: op_nxt = bpd_pkg::OP_Q;
            bpd_pkg::OP_Q:    op_nxt = bpd_pkg::OP_EQ;
            bpd_pkg::OP_EQ:   op_nxt = bpd_pkg::OP_T;
            bpd_pkg::OP_T: begin
              if (stat.t_big) begin
                kind_nxt  = bpd_pkg::FIN_TOVF;
                state_nxt = S_FIN;
              end else begin
                op_nxt = bpd_pkg::OP_VT;
              end
            end
            bpd_pkg::OP_VT:   op_nxt = bpd_pkg::OP_VTM;
            bpd_pkg::OP_VTM:  op_nxt = bpd_pkg::OP_RM;
            bpd_pkg::OP_RM:   op_nxt = bpd_pkg::OP_GT;
            bpd_pkg::OP_GT:   op_nxt = bpd_pkg::OP_DROP;
            bpd_pkg::OP_DROP: state_nxt = S_UPDATE;
            default:          op_nxt = bpd_pkg::OP_SQ_D;
          endcase
        end
      end
      S_UPDATE: begin
        if (stat.a_ovf) begin
          kind_nxt  = bpd_pkg::FIN_AOVF;
          state_nxt = S_FIN;
        end else if (stat.conv) begin
          kind_nxt  = bpd_pkg::FIN_CONV;
          state_nxt = S_FIN;
        end else if (last) begin
          kind_nxt  = bpd_pkg::FIN_LIMIT;
          state_nxt = S_FIN;
        end else begin
          i_nxt     = i_r + ITER_W'(1);
          op_nxt    = bpd_pkg::OP_SQ_D;
          state_nxt = S_ISSUE;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_iters_nxt = (kind_r == bpd_pkg::FIN_INVALID) ? '0
                                                           : iter_ext[bpd_pkg::ITERS_W-1:0];
          case (kind_r)
            bpd_pkg::FIN_CONV:  out_status_nxt = bpd_pkg::ST_CONV;
            bpd_pkg::FIN_LIMIT: out_status_nxt = bpd_pkg::ST_LIMIT;
            default:            out_status_nxt = bpd_pkg::ST_ERR;
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= bpd_pkg::OP_EXP_MUL;
      n_r          <= '0;
      i_r          <= '0;
      kind_r       <= bpd_pkg::FIN_INVALID;
      out_valid_r  <= 1'b0;
      out_iters_r  <= '0;
      out_status_r <= bpd_pkg::ST_CONV;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      n_r          <= n_nxt;
      i_r          <= i_nxt;
      kind_r       <= kind_nxt;
      out_valid_r  <= out_valid_nxt;
      out_iters_r  <= out_iters_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_iters  = out_iters_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  // A unit never reports completion in the cycle right after it was started.
  a_no_instant_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !stat.done)
    else $error("arith unit finished immediately after start");

  // Completion pulses only arrive while the sequencer waits for them.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> state_r == S_WAIT)
    else $error("unit done outside of wait state");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // The aim is only refined when the iteration neither ended nor overflowed.
  a_upd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (!stat.a_ovf && !stat.conv && !last))
    else $error("aim updated on a terminating iteration");
`endif

endmodule

>>> hdl/ballistic_pitch_drag_solver.sv
// Ballistic aim-height solver with linear air drag. Give it a target's
// horizontal distance (unsigned Q6.16 m) and height above the muzzle (signed
// Q5.16 m); it returns the aim height (signed Q5.16 m, saturated), the number
// of refinement iterations and a status (0 converged, 1 iteration limit,
// 2 zero distance, zero speed or overflow). The muzzle speed is set through
// cfg_we/cfg_data as unsigned Q7.8 m/s and resets to 20.0 m/s; write it only
// while no item is in flight. One item is processed at a time: a sequencer
// drives a shared byte-serial multiplier, a one-bit-per-cycle divider and a
// two-bit-per-cycle square root. The drag exponential is computed once per item,
// and each iteration is dominated by its three 64-step divisions. An invalid
// input skips all arithmetic and goes from the check state straight to the
// final state, where its result is offered once the output register is free.
// in_ready is high whenever the block is idle, even while the last result
// still waits on out_ready.
module ballistic_pitch_drag_solver #(
  parameter int MAX_ITERATIONS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bpd_pkg::LS_W-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bpd_pkg::D_W-1:0]           in_distance,
  input  logic signed [bpd_pkg::Y_W-1:0]    in_target_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpd_pkg::Y_W-1:0]    out_aim_height,
  output logic [bpd_pkg::ITERS_W-1:0]       out_iterations_used,
  output logic [1:0]                        out_status
);

  bpd_pkg::cmd_t  cmd;
  bpd_pkg::stat_t stat;

  bpd_ctrl #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_iters  (out_iterations_used),
    .out_status (out_status),
    .stat       (stat),
    .cmd        (cmd)
  );

  bpd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_distance      (in_distance),
    .in_target_height (in_target_height),
    .cmd              (cmd),
    .stat             (stat),
    .aim              (out_aim_height)
  );

endmodule
